FILE: src/lob_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lob_pkg
// Shared types and codes for the order book matcher.
// ----------------------------------------------------------------------------
package lob_pkg;

  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_PARTIAL  = 3'd1;
  localparam logic [2:0] ST_FILLED   = 3'd2;
  localparam logic [2:0] ST_CANCELED = 3'd3;
  localparam logic [2:0] ST_REJECTED = 3'd4;

  localparam logic [2:0] RR_NONE      = 3'd0;
  localparam logic [2:0] RR_DUPLICATE = 3'd1;
  localparam logic [2:0] RR_POST_X    = 3'd2;
  localparam logic [2:0] RR_NO_LIQ    = 3'd3;
  localparam logic [2:0] RR_MKT_REST  = 3'd4;
  localparam logic [2:0] RR_NOT_FOUND = 3'd5;
  localparam logic [2:0] RR_FULL      = 3'd6;

  localparam logic [1:0] TIF_GTC  = 2'd0;
  localparam logic [1:0] TIF_IOC  = 2'd1;
  localparam logic [1:0] TIF_FOK  = 2'd2;
  localparam logic [1:0] TIF_POST = 2'd3;

  localparam int SlotW = 129;  // {side, id, price, open qty, arrival}

  // Resting order record as stored in the slot memory.
  typedef struct packed {
    logic        side;
    logic [31:0] ident;
    logic [31:0] price;
    logic [31:0] qty_left;
    logic [31:0] arrival;
  } slot_t;

endpackage

FILE: src/limit_order_book_matcher_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limit_order_book_matcher_unit
// Order book with price-time priority; slots held in one RAM, scanned
// one slot per cycle.
// A cancel takes one pre-scan; a submit adds a best-maker scan ahead of each fill.
// One item at a time; busy drops after the status record.
// The slot RAM read port is the bottleneck: one slot read per cycle per scan.
// Reset (synchronous, rst_n low) clears valid bits and the arrival counter.
// Results are strobed one cycle each by out_valid; the receiver cannot stall.
// ----------------------------------------------------------------------------
module limit_order_book_matcher_unit #(
  parameter int MAX_ORDERS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_op,
  input  logic [31:0] in_order_id,
  input  logic        in_side,
  input  logic        in_order_type,
  input  logic [1:0]  in_time_in_force,
  input  logic [31:0] in_limit_price,
  input  logic [31:0] in_quantity,
  output logic        out_valid,
  output logic        out_kind,
  output logic [31:0] out_maker_id,
  output logic [31:0] out_taker_id,
  output logic [31:0] out_trade_price,
  output logic [31:0] out_trade_qty,
  output logic [31:0] out_maker_left,
  output logic        out_accepted,
  output logic [2:0]  out_status,
  output logic [2:0]  out_rej_code,
  output logic [31:0] out_executed_qty,
  output logic [31:0] out_remaining_qty,
  output logic        out_last
);
  import lob_pkg::*;

  localparam int IW = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
  localparam int CW = $clog2(MAX_ORDERS + 1);
  localparam int SW = 32 + CW;  // eligible sum never wraps

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;  // pre-scan: dup, post cross, fok sum
  localparam logic [2:0] S_DECIDE= 3'd2;
  localparam logic [2:0] S_BEST  = 3'd3;  // best-maker scan
  localparam logic [2:0] S_FILL  = 3'd4;  // read best slot
  localparam logic [2:0] S_TRADE = 3'd5;
  localparam logic [2:0] S_FINAL = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [MAX_ORDERS-1:0] valid_r, valid_nxt;
  logic [31:0] arr_r, arr_nxt;

  // item latch
  logic op_r, side_r, mkt_r;
  logic [1:0] tif_r;
  logic [31:0] id_r, lim_r, qty_r, rem_r, rem_nxt;

  // scan control
  logic [CW-1:0] cnt_r, cnt_nxt;      // issue counter
  logic          rv_r, rv_nxt;        // read data valid next cycle
  logic [IW-1:0] ridx_r, ridx_nxt;    // index of data arriving
  logic          found_r, found_nxt;
  logic [IW-1:0] fidx_r, fidx_nxt;
  logic          cross_r, cross_nxt;
  logic [SW-1:0] sum_r, sum_nxt;
  logic [31:0]   bprice_r, bprice_nxt, bage_r, bage_nxt;

  // RAM
  logic we;
  logic [IW-1:0] waddr, raddr;
  slot_t wdata, rdata;
  logic [SlotW-1:0] rdata_raw;

  lob_ram #(.Width(SlotW), .Depth(MAX_ORDERS)) u_slots (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata_raw)
  );
  assign rdata = slot_t'(rdata_raw);

  // Per-slot combinational checks on the returning read data
  logic rvalid, elig, better;
  logic [31:0] age;
  always_comb begin
    rvalid = rv_r && valid_r[ridx_r];
    elig   = rvalid && (rdata.side != side_r) &&
             (mkt_r || (side_r == 1'b0 ? rdata.price <= lim_r : rdata.price >= lim_r));
    age    = arr_r - rdata.arrival;
    if (!found_r) better = 1'b1;
    else if (rdata.price != bprice_r)
      better = (side_r == 1'b0) ? (rdata.price < bprice_r) : (rdata.price > bprice_r);
    else better = age > bage_r;
  end

  // free slot: lowest invalid
  logic          has_free;
  logic [IW-1:0] free_idx;
  always_comb begin
    has_free = 1'b0;
    free_idx = '0;
    for (int i = MAX_ORDERS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        has_free = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  logic [31:0] fill, mopen;
  assign fill  = (rem_r < rdata.qty_left) ? rem_r : rdata.qty_left;
  assign mopen = rdata.qty_left - fill;

  logic [31:0] exec;
  assign exec = qty_r - rem_r;

  // output register
  logic ov_nxt, ok_nxt, oacc_nxt;
  logic [31:0] omk_nxt, opr_nxt, otq_nxt, omo_nxt, oex_nxt, orm_nxt;
  logic [2:0] ost_nxt, orr_nxt;

  always_comb begin
    state_nxt = state_r;
    valid_nxt = valid_r;
    arr_nxt   = arr_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    rv_nxt    = 1'b0;
    ridx_nxt  = ridx_r;
    found_nxt = found_r;
    fidx_nxt  = fidx_r;
    cross_nxt = cross_r;
    sum_nxt   = sum_r;
    bprice_nxt= bprice_r;
    bage_nxt  = bage_r;
    we = 1'b0;
    waddr = fidx_r;
    wdata = rdata;
    raddr = cnt_r[IW-1:0];
    ov_nxt = 1'b0; ok_nxt = 1'b1; oacc_nxt = 1'b0;
    omk_nxt = '0; opr_nxt = '0; otq_nxt = '0; omo_nxt = '0; oex_nxt = '0; orm_nxt = '0;
    ost_nxt = ST_ACCEPTED; orr_nxt = RR_NONE;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_SCAN;
          rem_nxt   = in_quantity;
          cnt_nxt   = '0;
          found_nxt = 1'b0;
          cross_nxt = 1'b0;
          sum_nxt   = '0;
        end
      end
      S_SCAN, S_BEST: begin
        // issue one read per cycle, evaluate returning data
        if (cnt_r < CW'(MAX_ORDERS)) begin
          rv_nxt   = 1'b1;
          ridx_nxt = cnt_r[IW-1:0];
          cnt_nxt  = cnt_r + 1'b1;
        end
        if (state_r == S_SCAN) begin
          if (rvalid && rdata.ident == id_r && !found_r) begin
            found_nxt = 1'b1;
            fidx_nxt  = ridx_r;
            rem_nxt   = rdata.qty_left;  // cancel remainder
          end
          if (elig) begin
            cross_nxt = 1'b1;
            sum_nxt   = sum_r + {{CW{1'b0}}, rdata.qty_left};
          end
        end else if (elig && better) begin
          found_nxt  = 1'b1;
          fidx_nxt   = ridx_r;
          bprice_nxt = rdata.price;
          bage_nxt   = age;
        end
        if (!rv_r && cnt_r == CW'(MAX_ORDERS)) begin
          state_nxt = (state_r == S_SCAN) ? S_DECIDE : S_FILL;
        end
      end
      S_DECIDE: begin
        state_nxt = S_FINAL;
        ov_nxt = 1'b1;
        if (op_r) begin
          if (found_r) begin
            valid_nxt[fidx_r] = 1'b0;
            oacc_nxt = 1'b1; ost_nxt = ST_CANCELED; orm_nxt = rem_r;
          end else begin
            ost_nxt = ST_REJECTED; orr_nxt = RR_NOT_FOUND;
          end
        end else if (qty_r == '0) begin
          ost_nxt = ST_REJECTED; orr_nxt = RR_NO_LIQ;
        end else if (found_r) begin
          ost_nxt = ST_REJECTED; orr_nxt = RR_DUPLICATE; orm_nxt = qty_r;
        end else if (!mkt_r && tif_r == TIF_POST && cross_r) begin
          ost_nxt = ST_REJECTED; orr_nxt = RR_POST_X; orm_nxt = qty_r;
        end else if (tif_r == TIF_FOK && sum_r < {{CW{1'b0}}, qty_r}) begin
          ost_nxt = ST_REJECTED; orr_nxt = RR_NO_LIQ; orm_nxt = qty_r;
        end else begin
          ov_nxt    = 1'b0;
          rem_nxt   = qty_r;
          state_nxt = S_BEST;
          cnt_nxt   = '0;
          found_nxt = 1'b0;
        end
      end
      S_FILL: begin
        if (!found_r) begin
          state_nxt = S_FINAL;
          ov_nxt = 1'b1; oex_nxt = exec; orm_nxt = rem_r;
          if (mkt_r) begin
            if (tif_r == TIF_IOC || exec != '0) begin
              oacc_nxt = 1'b1;
              ost_nxt = (exec != '0) ? ST_PARTIAL : ST_CANCELED;
            end else begin
              ost_nxt = ST_REJECTED; orr_nxt = RR_MKT_REST; oex_nxt = '0;
            end
          end else if (tif_r == TIF_IOC) begin
            oacc_nxt = 1'b1;
            ost_nxt = (exec != '0) ? ST_PARTIAL : ST_CANCELED;
          end else if (!has_free) begin
            ost_nxt = ST_REJECTED; orr_nxt = RR_FULL;
          end else begin
            we = 1'b1;
            waddr = free_idx;
            wdata = '{side: side_r, ident: id_r, price: lim_r,
                      qty_left: rem_r, arrival: arr_r};
            valid_nxt[free_idx] = 1'b1;
            arr_nxt = arr_r + 32'd1;
            oacc_nxt = 1'b1;
            ost_nxt = (exec != '0) ? ST_PARTIAL : ST_ACCEPTED;
          end
        end else begin
          raddr = fidx_r;
          state_nxt = S_TRADE;
        end
      end
      S_TRADE: begin
        // read-modify-write of the best maker
        we = 1'b1;
        waddr = fidx_r;
        wdata = rdata;
        wdata.qty_left = mopen;
        if (mopen == '0) valid_nxt[fidx_r] = 1'b0;
        rem_nxt = rem_r - fill;
        ov_nxt = 1'b1; ok_nxt = 1'b0;
        omk_nxt = rdata.ident; opr_nxt = rdata.price;
        otq_nxt = fill; omo_nxt = mopen;
        cnt_nxt = '0;
        found_nxt = 1'b0;
        if (rem_r == fill) begin
          state_nxt = S_FINAL;
        end else begin
          state_nxt = S_BEST;
        end
      end
      S_FINAL: begin
        // filled status follows the last trade; stay busy until it is out
        if (!out_kind) begin
          ov_nxt = 1'b1; oacc_nxt = 1'b1; ost_nxt = ST_FILLED; oex_nxt = qty_r;
          state_nxt = S_FINAL;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      valid_r   <= '0;
      arr_r     <= '0;
      out_valid <= 1'b0;
      out_kind  <= 1'b1;
      rv_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      valid_r   <= valid_nxt;
      arr_r     <= arr_nxt;
      out_valid <= ov_nxt;
      out_kind  <= ok_nxt;
      rv_r      <= rv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      op_r <= in_op; id_r <= in_order_id; side_r <= in_side;
      mkt_r <= in_order_type; tif_r <= in_time_in_force;
      lim_r <= in_limit_price; qty_r <= in_quantity;
    end
    rem_r <= rem_nxt; cnt_r <= cnt_nxt; ridx_r <= ridx_nxt;
    found_r <= found_nxt; fidx_r <= fidx_nxt; cross_r <= cross_nxt;
    sum_r <= sum_nxt; bprice_r <= bprice_nxt; bage_r <= bage_nxt;
    out_maker_id <= omk_nxt; out_trade_price <= opr_nxt;
    out_trade_qty <= otq_nxt; out_maker_left <= omo_nxt;
    out_accepted <= oacc_nxt; out_status <= ost_nxt; out_rej_code <= orr_nxt;
    out_executed_qty <= oex_nxt; out_remaining_qty <= orm_nxt;
  end

  assign out_taker_id = id_r;
  assign out_last     = out_kind;
  assign busy         = (state_r != S_IDLE);

`ifndef SYNTHESIS
  a_trade_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_kind) |-> busy) else $error("trade strobe while idle");
  a_status_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind) |=> !busy) else $error("busy after status record");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid)) else $error("item not taken");
`endif
endmodule

FILE: src/lob_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lob_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lob_ram #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [$clog2((Depth > 1) ? Depth : 2)-1:0]  waddr,
  input  logic [Width-1:0]                            wdata,
  input  logic [$clog2((Depth > 1) ? Depth : 2)-1:0]  raddr,
  output logic [Width-1:0]                            rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
